/* sv/tlpw_pkg.sv */
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared types and constants of the two-level page walker.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned NumRes   = 3;

  localparam logic [CfgIdxW-1:0] CFG_DIR_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WP       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WP_HON   = 2'd2;

  localparam logic [31:0] PTE_ACCESSED       = 32'h0000_0020;
  localparam logic [31:0] PTE_ACCESSED_DIRTY = 32'h0000_0060;

  typedef enum logic {
    OP_REQUEST  = 1'b0,
    OP_RESPONSE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_TRANSLATED = 2'd0,
    ST_FAULT      = 2'd1,
    ST_REFUSED    = 2'd2,
    ST_DENIED     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DIR  = 2'd1,
    PH_TAB  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [19:0] dir_base;
    logic        wp;
    logic        wp_honored;
  } cfg_t;

  typedef struct packed {
    logic probe;
    logic ovr;
    logic user;
    logic wr;
  } flags_t;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] linear_address;
    flags_t      flags;
    logic        abort_pending;
    logic [31:0] read_data;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    status_e     status;
    logic [2:0]  error_code;
    logic [31:0] physical_address;
    logic        user_page;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [NumRes-1:0] res;
    logic [1:0]        cnt;
  } grp_t;

endpackage

/* sv/tlpw_cfg.sv */
// ----------------------------------------------------------------------------
// tlpw_cfg
// Configuration registers of the page walker.
// ----------------------------------------------------------------------------
module tlpw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [tlpw_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [tlpw_pkg::CfgDataW-1:0]  data_i,
  output tlpw_pkg::cfg_t                 cfg_o
);

  tlpw_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        tlpw_pkg::CFG_DIR_BASE: cfg_d.dir_base   = data_i;
        tlpw_pkg::CFG_WP:       cfg_d.wp         = data_i[0];
        tlpw_pkg::CFG_WP_HON:   cfg_d.wp_honored = data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_base   <= '0;
      cfg_q.wp         <= 1'b0;
      cfg_q.wp_honored <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/tlpw_walk.sv */
// ----------------------------------------------------------------------------
// tlpw_walk
// Walk state and the single-pass step logic that forms the result group.
// ----------------------------------------------------------------------------
module tlpw_walk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlpw_pkg::cfg_t cfg_i,
  input  logic           fire_i,
  input  tlpw_pkg::in_t  in_i,
  output tlpw_pkg::grp_t grp_o
);

  tlpw_pkg::phase_e phase_q, phase_d;
  logic [31:0]      held_q, held_d;
  tlpw_pkg::flags_t flags_q, flags_d;
  logic [31:0]      dent_q, dent_d;

  logic        w, u, ovr, prb;
  logic [2:0]  err;
  logic [31:0] rd, comb;
  logic        fail;
  logic [31:0] dir_wb_addr, tab_wb_addr, phys;
  tlpw_pkg::res_t done_r;

  assign w    = flags_q.wr;
  assign u    = flags_q.user;
  assign ovr  = flags_q.ovr;
  assign prb  = flags_q.probe;
  assign err  = {u, w, 1'b0};
  assign rd   = in_i.read_data;
  assign comb = rd & dent_q;

  always_comb begin
    fail = !rd[0] || (u && !comb[2] && !ovr);
    if (w && !comb[1]) begin
      if (prb) begin
        if (u || cfg_i.wp) fail = 1'b1;
      end else begin
        if ((u && !ovr) || (cfg_i.wp_honored && cfg_i.wp)) fail = 1'b1;
      end
    end
  end

  assign dir_wb_addr = {cfg_i.dir_base, held_q[31:22], 2'b00};
  assign tab_wb_addr = {dent_q[31:12], held_q[21:12], 2'b00};
  assign phys        = {rd[31:12], held_q[11:0]};

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    flags_d = flags_q;
    dent_d  = dent_q;
    if (in_i.opcode == tlpw_pkg::OP_REQUEST) begin
      if (!in_i.abort_pending) begin
        held_d  = in_i.linear_address;
        flags_d = in_i.flags;
        phase_d = tlpw_pkg::PH_DIR;
      end
    end else begin
      unique case (phase_q)
        tlpw_pkg::PH_DIR: begin
          if (rd[0]) begin
            dent_d  = rd;
            phase_d = tlpw_pkg::PH_TAB;
          end else begin
            phase_d = tlpw_pkg::PH_IDLE;
          end
        end
        tlpw_pkg::PH_TAB: phase_d = tlpw_pkg::PH_IDLE;
        default: ;
      endcase
    end
  end

  always_comb begin
    grp_o  = '0;
    done_r = '0;
    done_r.kind = tlpw_pkg::KIND_DONE;
    done_r.last = 1'b1;
    if (in_i.opcode == tlpw_pkg::OP_REQUEST) begin
      grp_o.cnt = 2'd1;
      if (in_i.abort_pending) begin
        grp_o.res[0]        = done_r;
        grp_o.res[0].status = tlpw_pkg::ST_REFUSED;
      end else begin
        grp_o.res[0].kind        = tlpw_pkg::KIND_READ;
        grp_o.res[0].mem_address = {cfg_i.dir_base, in_i.linear_address[31:22], 2'b00};
        grp_o.res[0].last        = 1'b1;
      end
    end else begin
      unique case (phase_q)
        tlpw_pkg::PH_DIR: begin
          grp_o.cnt = 2'd1;
          if (rd[0]) begin
            grp_o.res[0].kind        = tlpw_pkg::KIND_READ;
            grp_o.res[0].mem_address = {rd[31:12], held_q[21:12], 2'b00};
            grp_o.res[0].last        = 1'b1;
          end else begin
            grp_o.res[0] = done_r;
            if (prb) begin
              grp_o.res[0].status = tlpw_pkg::ST_DENIED;
            end else begin
              grp_o.res[0].status     = tlpw_pkg::ST_FAULT;
              grp_o.res[0].error_code = err;
            end
          end
        end
        tlpw_pkg::PH_TAB: begin
          if (fail) begin
            grp_o.cnt    = 2'd1;
            grp_o.res[0] = done_r;
            if (prb) begin
              grp_o.res[0].status = tlpw_pkg::ST_DENIED;
            end else begin
              grp_o.res[0].status     = tlpw_pkg::ST_FAULT;
              grp_o.res[0].error_code = err | {2'b00, rd[0]};
            end
          end else if (prb) begin
            grp_o.cnt                     = 2'd1;
            grp_o.res[0]                  = done_r;
            grp_o.res[0].physical_address = phys;
            grp_o.res[0].user_page        = rd[2];
          end else begin
            grp_o.cnt                     = 2'd3;
            grp_o.res[0].kind             = tlpw_pkg::KIND_WRITE;
            grp_o.res[0].mem_address      = dir_wb_addr;
            grp_o.res[0].mem_data         = dent_q | tlpw_pkg::PTE_ACCESSED;
            grp_o.res[1].kind             = tlpw_pkg::KIND_WRITE;
            grp_o.res[1].mem_address      = tab_wb_addr;
            grp_o.res[1].mem_data         = rd | (w ? tlpw_pkg::PTE_ACCESSED_DIRTY
                                                    : tlpw_pkg::PTE_ACCESSED);
            grp_o.res[2]                  = done_r;
            grp_o.res[2].physical_address = phys;
            grp_o.res[2].user_page        = rd[2];
          end
        end
        default: grp_o.cnt = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tlpw_pkg::PH_IDLE;
      held_q  <= '0;
      flags_q <= '0;
      dent_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      flags_q <= flags_d;
      dent_q  <= dent_d;
    end
  end

endmodule

/* sv/tlpw_out.sv */
// ----------------------------------------------------------------------------
// tlpw_out
// Result register that holds one result group and hands out its items in order.
// ----------------------------------------------------------------------------
module tlpw_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  tlpw_pkg::grp_t grp_i,
  output logic           free_o,
  output logic           valid_o,
  input  logic           ready_i,
  output tlpw_pkg::res_t res_o
);

  tlpw_pkg::grp_t grp_q;
  logic           v_q, v_d;
  logic [1:0]     idx_q, idx_d;
  logic           at_end;

  assign at_end  = (idx_q == grp_q.cnt - 2'd1);
  assign free_o  = !v_q || (ready_i && at_end);
  assign valid_o = v_q;
  assign res_o   = grp_q.res[idx_q];

  always_comb begin
    v_d   = v_q;
    idx_d = idx_q;
    if (v_q && ready_i) begin
      if (at_end) begin
        v_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      v_d   = (grp_i.cnt != 2'd0);
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      v_q   <= v_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

endmodule

/* sv/two_level_page_walker_core.sv */
// ----------------------------------------------------------------------------
// two_level_page_walker_core
// Two-level page table walker for 32-bit linear addresses.
// ----------------------------------------------------------------------------
// The slave stream takes requests (tuser low) and memory read responses
// (tuser high). The master stream gives memory reads, entry write-backs and
// a done item with status, fault code and physical address; tlast marks the
// final item caused by one input item. The configuration port writes the
// directory frame and the write-protect controls; write them only while the
// block is idle, which the block itself does not enforce. An accepted item
// enters an input register; once the result register is free, the walk logic
// updates the walk state and loads the result register from it. Items are
// taken one per cycle as long as each causes at most one result and the
// receiver does not stall; a successful normal walk ends with three result
// items, which occupy the result register until all three are taken. A
// response that arrives with no walk in progress causes no result.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; tready on the slave side then drops.
// Reset leaves the walker idle with no item held, the directory frame and
// write-protect flag clear and write-protect honoring on.
// ----------------------------------------------------------------------------
module two_level_page_walker_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tlpw_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [tlpw_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // linear_address, is_write, user_mode, privilege_override, probe,
  // abort_pending, read_data, zero fill
  input  logic [tlpw_pkg::InDataW-1:0]           s_axis_tdata,
  // opcode
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // mem_address, mem_data, status, error_code, physical_address, user_page,
  // zero fill
  output logic [tlpw_pkg::OutDataW-1:0]          m_axis_tdata,
  // kind
  output logic [1:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast
);

  tlpw_pkg::cfg_t cfg;
  tlpw_pkg::in_t  in_q, in_d;
  logic           in_v_q;
  logic           fire, out_free;
  tlpw_pkg::grp_t grp;
  tlpw_pkg::res_t res;

  assign fire          = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || out_free;

  always_comb begin
    in_d.opcode         = tlpw_pkg::opcode_e'(s_axis_tuser);
    in_d.linear_address = s_axis_tdata[31:0];
    in_d.flags.wr       = s_axis_tdata[32];
    in_d.flags.user     = s_axis_tdata[33];
    in_d.flags.ovr      = s_axis_tdata[34];
    in_d.flags.probe    = s_axis_tdata[35];
    in_d.abort_pending  = s_axis_tdata[36];
    in_d.read_data      = s_axis_tdata[68:37];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_d;
    end
  end

  tlpw_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  tlpw_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .in_i   (in_q),
    .grp_o  (grp)
  );

  tlpw_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .grp_i   (grp),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {2'b00, res.user_page, res.physical_address, res.error_code,
                         res.status, res.mem_data, res.mem_address};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

/* tb/two_level_page_walker_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_walker_core_tb
// Self-checking testbench of the two-level page walker core.
// ----------------------------------------------------------------------------
// Requests and memory responses go in on the slave stream. Every accepted item
// is also applied to a behavioral walker kept inside the testbench. That walker
// queues the memory reads, entry write-backs and done items it predicts. Each
// item on the master stream is checked field by field against the oldest
// prediction. Directed walks cover refusal, absent entries, permission faults,
// probes and interrupted walks. Random walks follow under several register
// settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module two_level_page_walker_core_tb;

  localparam int CycleLimit  = 200000;
  localparam int SettleCycles = 8;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni;
  logic                                   cfg_we_i;
  logic [tlpw_pkg::CfgIdxW-1:0]           cfg_idx_i;
  logic [tlpw_pkg::CfgDataW-1:0]          cfg_data_i;
  logic                                   s_axis_tvalid;
  logic                                   s_axis_tready;
  logic [tlpw_pkg::InDataW-1:0]           s_axis_tdata;
  logic                                   s_axis_tuser;
  logic                                   m_axis_tvalid;
  logic                                   m_axis_tready = 1'b0;
  logic [tlpw_pkg::OutDataW-1:0]          m_axis_tdata;
  logic [1:0]                             m_axis_tuser;
  logic                                   m_axis_tlast;

  tlpw_pkg::cfg_t   model_cfg;
  tlpw_pkg::phase_e walk_phase;
  logic [31:0]      held_la;
  tlpw_pkg::flags_t held_fl;
  logic [31:0]      held_dir;
  tlpw_pkg::res_t   walk_results_q[$];

  int error_count = 0;
  int handled_items;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_stall_pct;

  two_level_page_walker_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic tlpw_pkg::flags_t mk_flags(logic wr, logic user, logic ovr, logic prb);
    tlpw_pkg::flags_t f;
    f.wr    = wr;
    f.user  = user;
    f.ovr   = ovr;
    f.probe = prb;
    return f;
  endfunction

  function automatic tlpw_pkg::flags_t rand_flags();
    return tlpw_pkg::flags_t'(4'($urandom_range(15)));
  endfunction

  function automatic tlpw_pkg::in_t mk_request(logic [31:0] la, tlpw_pkg::flags_t f,
                                               logic abort);
    tlpw_pkg::in_t it;
    it.opcode         = tlpw_pkg::OP_REQUEST;
    it.linear_address = la;
    it.flags          = f;
    it.abort_pending  = abort;
    it.read_data      = $urandom;
    return it;
  endfunction

  function automatic tlpw_pkg::in_t mk_response(logic [31:0] entry);
    tlpw_pkg::in_t it;
    it.opcode         = tlpw_pkg::OP_RESPONSE;
    it.linear_address = $urandom;
    it.flags          = rand_flags();
    it.abort_pending  = 1'($urandom_range(1));
    it.read_data      = entry;
    return it;
  endfunction

  function automatic logic [31:0] rand_entry();
    logic [31:0] e;
    e    = $urandom;
    e[0] = ($urandom_range(99) < 85);
    return e;
  endfunction

  function automatic logic [31:0] dir_entry_addr();
    return {model_cfg.dir_base, held_la[31:22], 2'b00};
  endfunction

  function automatic logic [31:0] tab_entry_addr();
    return {held_dir[31:12], held_la[21:12], 2'b00};
  endfunction

  function automatic void push_result(tlpw_pkg::kind_e k, logic [31:0] maddr,
                                      logic [31:0] mdata, tlpw_pkg::status_e st,
                                      logic [2:0] ec, logic [31:0] pa,
                                      logic up, logic lst);
    tlpw_pkg::res_t r;
    r.kind             = k;
    r.mem_address      = maddr;
    r.mem_data         = mdata;
    r.status           = st;
    r.error_code       = ec;
    r.physical_address = pa;
    r.user_page        = up;
    r.last             = lst;
    walk_results_q.push_back(r);
  endfunction

  function automatic void walk_step(tlpw_pkg::in_t it);
    logic [31:0] entry;
    logic [31:0] comb;
    logic [31:0] phys;
    logic [2:0]  err;
    logic        fail;
    if (it.opcode == tlpw_pkg::OP_REQUEST) begin
      handled_items++;
      if (it.abort_pending) begin
        push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_REFUSED, '0, '0, 1'b0, 1'b1);
      end else begin
        held_la    = it.linear_address;
        held_fl    = it.flags;
        walk_phase = tlpw_pkg::PH_DIR;
        push_result(tlpw_pkg::KIND_READ, dir_entry_addr(), '0, tlpw_pkg::ST_TRANSLATED, '0,
                    '0, 1'b0, 1'b1);
      end
    end else if (walk_phase != tlpw_pkg::PH_IDLE) begin
      handled_items++;
      entry = it.read_data;
      err   = {held_fl.user, held_fl.wr, 1'b0};
      if (walk_phase == tlpw_pkg::PH_DIR) begin
        if (!entry[0]) begin
          walk_phase = tlpw_pkg::PH_IDLE;
          if (held_fl.probe) begin
            push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_DENIED, '0, '0, 1'b0, 1'b1);
          end else begin
            push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_FAULT, err, '0, 1'b0, 1'b1);
          end
        end else begin
          held_dir   = entry;
          walk_phase = tlpw_pkg::PH_TAB;
          push_result(tlpw_pkg::KIND_READ, tab_entry_addr(), '0, tlpw_pkg::ST_TRANSLATED, '0,
                      '0, 1'b0, 1'b1);
        end
      end else begin
        walk_phase = tlpw_pkg::PH_IDLE;
        comb = entry & held_dir;
        fail = !entry[0] || (held_fl.user && !comb[2] && !held_fl.ovr);
        if (held_fl.wr && !comb[1]) begin
          if (held_fl.probe) begin
            fail |= held_fl.user || model_cfg.wp;
          end else begin
            fail |= (held_fl.user && !held_fl.ovr) || (model_cfg.wp_honored && model_cfg.wp);
          end
        end
        phys = {entry[31:12], held_la[11:0]};
        if (fail) begin
          if (held_fl.probe) begin
            push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_DENIED, '0, '0, 1'b0, 1'b1);
          end else begin
            push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_FAULT,
                        err | {2'b00, entry[0]}, '0, 1'b0, 1'b1);
          end
        end else if (held_fl.probe) begin
          push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_TRANSLATED, '0, phys,
                      entry[2], 1'b1);
        end else begin
          push_result(tlpw_pkg::KIND_WRITE, dir_entry_addr(),
                      held_dir | tlpw_pkg::PTE_ACCESSED,
                      tlpw_pkg::ST_TRANSLATED, '0, '0, 1'b0, 1'b0);
          push_result(tlpw_pkg::KIND_WRITE, tab_entry_addr(),
                      entry | (held_fl.wr ? tlpw_pkg::PTE_ACCESSED_DIRTY
                                          : tlpw_pkg::PTE_ACCESSED),
                      tlpw_pkg::ST_TRANSLATED, '0, '0, 1'b0, 1'b0);
          push_result(tlpw_pkg::KIND_DONE, '0, '0, tlpw_pkg::ST_TRANSLATED, '0, phys,
                      entry[2], 1'b1);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  task automatic check_result();
    tlpw_pkg::res_t want;
    if (walk_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result item of kind %0d", m_axis_tuser));
    end else begin
      want = walk_results_q.pop_front();
      compare_field("kind", 32'(m_axis_tuser), 32'(want.kind));
      compare_field("mem_address", m_axis_tdata[31:0], want.mem_address);
      compare_field("mem_data", m_axis_tdata[63:32], want.mem_data);
      compare_field("status", 32'(m_axis_tdata[65:64]), 32'(want.status));
      compare_field("error_code", 32'(m_axis_tdata[68:66]), 32'(want.error_code));
      compare_field("physical_address", m_axis_tdata[100:69], want.physical_address);
      compare_field("user_page", 32'(m_axis_tdata[101]), 32'(want.user_page));
      compare_field("last", 32'(m_axis_tlast), 32'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  task automatic send_item(input tlpw_pkg::in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.read_data, it.abort_pending, it.flags, it.linear_address};
    s_axis_tuser  <= it.opcode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    walk_step(it);
  endtask

  task automatic walk(input logic [31:0] la, input tlpw_pkg::flags_t f,
                      input logic [31:0] dir_e, input logic [31:0] tab_e);
    send_item(mk_request(la, f, 1'b0));
    send_item(mk_response(dir_e));
    send_item(mk_response(tab_e));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tlpw_pkg::CfgIdxW-1:0] idx,
                           input logic [tlpw_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      tlpw_pkg::CFG_DIR_BASE: model_cfg.dir_base   = value;
      tlpw_pkg::CFG_WP:       model_cfg.wp         = value[0];
      tlpw_pkg::CFG_WP_HON:   model_cfg.wp_honored = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [19:0] base, input logic wp, input logic hon);
    while (walk_phase != tlpw_pkg::PH_IDLE) send_item(mk_response(32'h0000_0000));
    drain_results();
    write_reg(tlpw_pkg::CFG_DIR_BASE, base);
    write_reg(tlpw_pkg::CFG_WP, 20'(wp));
    write_reg(tlpw_pkg::CFG_WP_HON, 20'(hon));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_refused();
    send_item(mk_request($urandom, rand_flags(), 1'b1));
    // The refusal must leave the walk in progress untouched.
    send_item(mk_request(32'h1234_5678, mk_flags(1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    send_item(mk_request(32'hFFFF_0000, mk_flags(1'b0, 1'b0, 1'b0, 1'b1), 1'b1));
    send_item(mk_response(32'h0ABC_D007));
    send_item(mk_response(32'h5555_5007));
  endtask

  task automatic test_dir_absent();
    send_item(mk_request(32'hDEAD_BEEF, mk_flags(1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    send_item(mk_response(32'hFFFF_FFFE));
    send_item(mk_request(32'h8000_1000, mk_flags(1'b0, 1'b0, 1'b0, 1'b1), 1'b0));
    send_item(mk_response(32'h0000_0000));
  endtask

  task automatic test_translate();
    walk(32'h0000_0000, mk_flags(1'b0, 1'b0, 1'b0, 1'b0), 32'h0000_0001, 32'hFFFF_F007);
    walk(32'hFFFF_FFFF, mk_flags(1'b1, 1'b1, 1'b0, 1'b0), 32'hFFFF_F007, 32'hFFFF_FFFF);
  endtask

  task automatic test_interrupts();
    send_item(mk_response(32'hFFFF_FFFF));
    send_item(mk_request(32'h0040_2000, mk_flags(1'b0, 1'b1, 1'b1, 1'b0), 1'b0));
    send_item(mk_response(32'h0010_0007));
    // A new request abandons the walk that waits for its table entry.
    walk(32'h7FC0_3ABC, mk_flags(1'b1, 1'b0, 1'b0, 1'b0), 32'h0020_0003, 32'h0030_0003);
  endtask

  task automatic test_permissions();
    walk(32'h0123_4567, mk_flags(1'b0, 1'b1, 1'b0, 1'b0), 32'h0000_0007, 32'h0044_4003);
    set_config(20'hFFFFF, 1'b1, 1'b1);
    walk(32'hC000_0FFF, mk_flags(1'b1, 1'b0, 1'b0, 1'b0), 32'h0000_0001, 32'hFFFF_FFFD);
    // A probe obeys the write-protect flag even where normal walks do not.
    set_config(20'h00000, 1'b1, 1'b0);
    walk(32'h3FFF_F000, mk_flags(1'b1, 1'b0, 1'b0, 1'b1), 32'hFFFF_F005, 32'h1234_5005);
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    int target;
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = handled_items + n;
    while (handled_items < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        walk($urandom, rand_flags(), rand_entry(), rand_entry());
      end else if (pick < 78) begin
        send_item(mk_request($urandom, rand_flags(), 1'b1));
      end else if (pick < 88) begin
        send_item(mk_request($urandom, rand_flags(), 1'b0));
      end else if (pick < 97) begin
        send_item(mk_response(rand_entry()));
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    handled_items  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_cfg.dir_base   = '0;
    model_cfg.wp         = 1'b0;
    model_cfg.wp_honored = 1'b1;
    walk_phase = tlpw_pkg::PH_IDLE;
    held_la    = '0;
    held_fl    = '0;
    held_dir   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_refused();
    test_dir_absent();
    test_translate();
    test_interrupts();
    test_permissions();

    set_config(20'h00000, 1'b0, 1'b1);
    test_random(90, 0, 0);
    set_config(20'hFFFFF, 1'b1, 1'b1);
    test_random(90, 46, 0);
    set_config(20'($urandom), 1'b1, 1'b0);
    test_random(90, 0, 46);
    set_config(20'($urandom), 1'b0, 1'b0);
    test_random(90, 9, 9);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* two_level_page_walker_core.f */
sv/tlpw_pkg.sv
sv/tlpw_cfg.sv
sv/tlpw_walk.sv
sv/tlpw_out.sv
sv/two_level_page_walker_core.sv
tb/two_level_page_walker_core_tb.sv
